// File: hdl/t2o3_pkg.sv
// Shared types and constants for the triplet two-out-of-three coincidence block.
`default_nettype none

package t2o3_pkg;

	// Fixed field widths of the transfer payloads.
	localparam int LAYER_BITS = 36;
	localparam int HALF_BITS  = 50;
	localparam int POS_BITS   = 5;

	// Widest coincidence row that the result halves and sections may see.
	localparam int MAX_ROW = 192;

	// Default geometry of the triplet.
	localparam int DEF_LAYER_CHANNELS = 36;
	localparam int DEF_COINC_CHANNELS = 100;
	localparam int DEF_EDGE_SKIP      = 2;
	localparam int DEF_SECTION_COUNT  = 3;

	// Number of section outputs carried in the result.
	localparam int SECTION_SLOTS = 3;

	// Width of the window of interleaved bits behind one coincidence channel.
	localparam int WINDOW_SPAN = 8;

	typedef struct packed {
		logic [LAYER_BITS-1:0] layer0_hits;
		logic [LAYER_BITS-1:0] layer1_hits;
		logic [LAYER_BITS-1:0] layer2_hits;
	} hits_t;

	typedef struct packed {
		logic [HALF_BITS-1:0] coinc_lower;
		logic [HALF_BITS-1:0] coinc_upper;
		logic                 hit_a;
		logic [POS_BITS-1:0]  pos_a;
		logic                 hit_b;
		logic [POS_BITS-1:0]  pos_b;
		logic                 hit_c;
		logic [POS_BITS-1:0]  pos_c;
	} result_t;

endpackage

`default_nettype wire

// File: hdl/t2o3_coinc_row.sv
// Interleaves the three layer words and forms the two-out-of-three coincidence row.
`default_nettype none

module t2o3_coinc_row #(
	parameter int LAYER_CHANNELS = t2o3_pkg::DEF_LAYER_CHANNELS,
	parameter int COINC_CHANNELS = t2o3_pkg::DEF_COINC_CHANNELS
) (
	input  wire t2o3_pkg::hits_t      hits,
	output logic [COINC_CHANNELS-1:0] coinc
);
	import t2o3_pkg::*;

	localparam int UNITS = (LAYER_CHANNELS > 64) ? 64 : LAYER_CHANNELS;
	localparam int TOTAL = 3 * UNITS;

	logic [TOTAL-1:0] ilv;

	// Interleave channel by channel; channels beyond the field width read as zero.
	for (genvar g = 0; g < UNITS; g++) begin : g_ilv
		if (g < LAYER_BITS) begin : g_live
			assign ilv[3*g]   = hits.layer0_hits[g];
			assign ilv[3*g+1] = hits.layer1_hits[g];
			assign ilv[3*g+2] = hits.layer2_hits[g];
		end else begin : g_dead
			assign ilv[3*g +: 3] = 3'b000;
		end
	end

	// Each channel looks at interleaved positions i+1 to i+7; the row tail has no full window.
	for (genvar g = 0; g < COINC_CHANNELS; g++) begin : g_coinc
		if (g < TOTAL - WINDOW_SPAN) begin : g_win
			logic b1, b2, b3, b4, b5, b6, b7;
			assign b1 = ilv[g+1];
			assign b2 = ilv[g+2];
			assign b3 = ilv[g+3];
			assign b4 = ilv[g+4];
			assign b5 = ilv[g+5];
			assign b6 = ilv[g+6];
			assign b7 = ilv[g+7];
			assign coinc[g] = (b3 & b5 & ~b1 & ~b7) |
			                  (b3 & b4 & ~b2) |
			                  (b4 & b5 & ~b6) |
			                  (b2 & b4 & b6 & ~b1 & ~b3 & ~b5 & ~b7);
		end else begin : g_tail
			assign coinc[g] = 1'b0;
		end
	end

endmodule

`default_nettype wire

// File: hdl/t2o3_section_enc.sv
// Hit flag and lowest set channel offset for one section of the coincidence row.
`default_nettype none

module t2o3_section_enc #(
	parameter int COINC_CHANNELS = t2o3_pkg::DEF_COINC_CHANNELS,
	parameter int START          = 0,
	parameter int SEC_LEN        = 1
) (
	input  wire [COINC_CHANNELS-1:0]       coinc,
	output logic                           hit,
	output logic [t2o3_pkg::POS_BITS-1:0]  pos
);
	import t2o3_pkg::*;

	logic [SEC_LEN-1:0] slice;

	assign slice = coinc[START +: SEC_LEN];
	assign hit   = |slice;

	// Priority pick: scanning down lets the lowest set channel win.
	always_comb begin
		pos = '0;
		for (int j = SEC_LEN - 1; j >= 0; j--) begin
			if (slice[j]) begin
				pos = POS_BITS'(j);
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/triplet_two_of_three_coincidence.sv
// Top level: input register, coincidence row and section encoders, result register.
// done is driven by the result stage flag valid_s2, which is loaded from the input stage flag valid_s1.
// Throughput: one transfer per clock cycle; busy is always low, the pipeline never stalls.
// The rate is set by the single pass of coincidence logic between the two register stages.
// Reset (arst_n low) clears the stage valid flags at once; payload registers are not reset.
`default_nettype none

module triplet_two_of_three_coincidence #(
	parameter int LAYER_CHANNELS = t2o3_pkg::DEF_LAYER_CHANNELS,
	parameter int COINC_CHANNELS = t2o3_pkg::DEF_COINC_CHANNELS,
	parameter int EDGE_SKIP      = t2o3_pkg::DEF_EDGE_SKIP,
	parameter int SECTION_COUNT  = t2o3_pkg::DEF_SECTION_COUNT
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire t2o3_pkg::hits_t hits,
	output logic                done,
	output t2o3_pkg::result_t   result
);
	import t2o3_pkg::*;

	localparam int SPAN    = COINC_CHANNELS - 2 * EDGE_SKIP;
	localparam int SEC_LEN = (SPAN < 0 || SECTION_COUNT <= 0) ? 0 : SPAN / SECTION_COUNT;

	logic                      valid_s1;
	hits_t                     hits_s1;
	logic                      valid_s2;
	result_t                   res_s2;
	logic [COINC_CHANNELS-1:0] coinc;
	logic [MAX_ROW-1:0]        row_ext;
	logic [SECTION_SLOTS-1:0]  sec_hit;
	logic [POS_BITS-1:0]       sec_pos [SECTION_SLOTS];
	result_t                   res_next;
	logic                      take;

	// The pipeline never stalls, so every start is a transfer.
	assign busy = 1'b0;
	assign take = start & ~busy;

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (take) begin
			hits_s1 <= hits;
		end
	end

	t2o3_coinc_row #(
		.LAYER_CHANNELS (LAYER_CHANNELS),
		.COINC_CHANNELS (COINC_CHANNELS)
	) u_row (
		.hits  (hits_s1),
		.coinc (coinc)
	);

	// Sections that exist get an encoder; the others report no hit.
	for (genvar s = 0; s < SECTION_SLOTS; s++) begin : g_sec
		if (s < SECTION_COUNT && SEC_LEN > 0) begin : g_live
			t2o3_section_enc #(
				.COINC_CHANNELS (COINC_CHANNELS),
				.START          (EDGE_SKIP + s * SEC_LEN),
				.SEC_LEN        (SEC_LEN)
			) u_enc (
				.coinc (coinc),
				.hit   (sec_hit[s]),
				.pos   (sec_pos[s])
			);
		end else begin : g_idle
			assign sec_hit[s] = 1'b0;
			assign sec_pos[s] = '0;
		end
	end

	// Pad the row so both halves are defined for any channel count up to MAX_ROW.
	assign row_ext = {{(MAX_ROW - COINC_CHANNELS){1'b0}}, coinc};

	always_comb begin
		res_next.coinc_lower = row_ext[HALF_BITS-1:0];
		res_next.coinc_upper = row_ext[2*HALF_BITS-1:HALF_BITS];
		res_next.hit_a       = sec_hit[0];
		res_next.pos_a       = sec_pos[0];
		res_next.hit_b       = sec_hit[1];
		res_next.pos_b       = sec_pos[1];
		res_next.hit_c       = sec_hit[2];
		res_next.pos_c       = sec_pos[2];
	end

	// Result stage payload.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= res_next;
		end
	end

	assign done   = valid_s2;
	assign result = res_s2;

`ifndef ASSERT_OFF
	// A result is shown only for a matching transfer taken earlier.
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take, 2))
		else $error("done without a matching transfer");

	// Every transfer reaches the result stage.
	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> ##1 done)
		else $error("transfer lost in the pipeline");

	// A section without a hit reports offset zero.
	a_pos_a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit_a) |-> (result.pos_a == '0))
		else $error("section a offset set without hit");

	a_pos_b_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit_b) |-> (result.pos_b == '0))
		else $error("section b offset set without hit");

	a_pos_c_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit_c) |-> (result.pos_c == '0))
		else $error("section c offset set without hit");
`endif

endmodule

`default_nettype wire
